// ===== sv/grid_obstacle_section_select_assert.svh =====
// Assertion macros shared by the grid obstacle section selector modules.
// The including module must have signals named clk and arst_n in scope.
`ifndef GRID_OBSTACLE_SECTION_SELECT_ASSERT_SVH
`define GRID_OBSTACLE_SECTION_SELECT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GOS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define GOS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/gos_pkg.sv =====
// Shared types, constants and helper functions of the grid obstacle section selector.
// Used by the register block, the controller, the datapath and the top level.
package gos_pkg;

	localparam int SIZE_W       = 13;
	localparam int DISP_THR_W   = 8;
	localparam int PCT_W        = 7;
	localparam int SEC_W        = 4;
	localparam int NUM_SECTIONS = 9;
	localparam int GRID_DIM     = 3;
	localparam int CNT_W        = 21;
	localparam int NUM_W        = CNT_W + 7;
	localparam int DIV_STEPS    = 7;
	localparam int STEP_W       = 3;
	localparam int DEN_W        = CNT_W + DIV_STEPS - 1;
	localparam int APB_ADDR_W   = 4;
	localparam int APB_DATA_W   = 32;

	localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};
	localparam logic [PCT_W-1:0] PERCENT_FULL = 7'd100;
	localparam logic [NUM_W-1:0] PERCENT_MUL  = NUM_W'(100);
	localparam logic [SEC_W-1:0] LAST_SECTION = SEC_W'(NUM_SECTIONS - 1);
	localparam logic [SIZE_W-1:0] MIN_SIZE    = 13'd3;

	// x/3 as a multiply by ceil(2^17/3); exact for x below 2^15.
	localparam logic [16:0] RECIP3      = 17'd43691;
	localparam int          RECIP3_SHIFT = 17;

	localparam int DEF_MAX_WIDTH      = 4096;
	localparam int DEF_MAX_HEIGHT     = 4096;
	localparam int DEF_DISPARITY_BITS = 8;

	localparam logic [SIZE_W-1:0]     RST_FRAME_WIDTH   = 13'd1280;
	localparam logic [SIZE_W-1:0]     RST_FRAME_HEIGHT  = 13'd720;
	localparam logic [DISP_THR_W-1:0] RST_DISP_THR      = 8'd120;
	localparam logic [PCT_W-1:0]      RST_PCT_THR       = 7'd20;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_DISP_THR     = 2'd2,
		REG_PCT_THR      = 2'd3
	} gos_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_NEXT,
		S_DONE
	} gos_state_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size_w;
		logic [SIZE_W-1:0] size_h;
		logic [SIZE_W-1:0] b1_w;
		logic [SIZE_W-1:0] b2_w;
		logic [SIZE_W-1:0] b1_h;
		logic [SIZE_W-1:0] b2_h;
	} gos_geom_t;

	typedef struct packed {
		logic             div_load;
		logic             div_step;
		logic             best_update;
		logic             publish;
		logic [SEC_W-1:0] sec_idx;
	} gos_cmd_t;

	typedef struct packed {
		logic frame_end_s1;
		logic out_free;
	} gos_status_t;

	function automatic logic [SIZE_W-1:0] div3(input logic [SIZE_W:0] x);
		logic [SIZE_W+17:0] p;
		p = (SIZE_W+18)'(x) * (SIZE_W+18)'(RECIP3);
		return SIZE_W'(p >> RECIP3_SHIFT);
	endfunction

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W:0] maxv);
		logic [SIZE_W-1:0] r;
		if (v < MIN_SIZE) begin
			r = MIN_SIZE;
		end else if ({1'b0, v} > maxv) begin
			r = SIZE_W'(maxv);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== sv/grid_obstacle_section_select.sv =====
// Grid obstacle section selector. Disparity pixels arrive in raster order, one
// transaction per pixel, and are counted per cell of a 3x3 grid (boundaries at 0,
// size/3 and 2*size/3 of the clamped frame size), both in total and where the
// disparity exceeds disparity_threshold. Within a frame a pixel is taken every
// clock. The last pixel of a frame starts the end-of-frame sweep: each of the nine
// sections in turn goes through a shared 7-step restoring divider (load, 7 steps,
// compare), and pixel input is stalled from then until the result is published. The
// result sits in an output register, so the next frame streams in while it waits;
// only the following frame end waits for it to be taken. Input is also stalled in
// the cycle after reset and after each register write while the grid boundaries
// are recomputed. Depends on gos_pkg.
module grid_obstacle_section_select #(
	parameter int MAX_WIDTH      = gos_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT     = gos_pkg::DEF_MAX_HEIGHT,
	parameter int DISPARITY_BITS = gos_pkg::DEF_DISPARITY_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gos_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [gos_pkg::APB_DATA_W-1:0] pwdata,
	output logic [gos_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [DISPARITY_BITS-1:0]      disparity,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [gos_pkg::SEC_W-1:0]      selected_section,
	output logic                           none_clear,
	output logic [gos_pkg::PCT_W-1:0]      min_percent
);
	import gos_pkg::*;

	gos_geom_t             geom;
	logic [DISP_THR_W-1:0] disp_thr;
	logic [PCT_W-1:0]      pct_thr;
	logic                  cfg_busy;
	gos_cmd_t              cmd;
	gos_status_t           status;
	logic                  in_accept;

	assign in_accept = in_valid & ~in_stall;

	gos_cfg_regs #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.geom     (geom),
		.disp_thr (disp_thr),
		.pct_thr  (pct_thr),
		.cfg_busy (cfg_busy)
	);

	gos_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.cfg_busy (cfg_busy),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	gos_datapath #(
		.MAX_WIDTH      (MAX_WIDTH),
		.MAX_HEIGHT     (MAX_HEIGHT),
		.DISPARITY_BITS (DISPARITY_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_accept        (in_accept),
		.disparity        (disparity),
		.geom             (geom),
		.disp_thr         (disp_thr),
		.pct_thr          (pct_thr),
		.cmd              (cmd),
		.status           (status),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.selected_section (selected_section),
		.none_clear       (none_clear),
		.min_percent      (min_percent)
	);

endmodule

// ===== sv/gos_cfg_regs.sv =====
// Configuration registers behind the APB port, plus the registered frame geometry
// (clamped sizes and grid boundaries) derived from them. Depends on gos_pkg.
module gos_cfg_regs #(
	parameter int MAX_WIDTH  = gos_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = gos_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gos_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [gos_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [gos_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	output gos_pkg::gos_geom_t                  geom,
	output logic [gos_pkg::DISP_THR_W-1:0]      disp_thr,
	output logic [gos_pkg::PCT_W-1:0]           pct_thr,
	output logic                                cfg_busy
);
	import gos_pkg::*;

	logic [SIZE_W-1:0]     frame_width_q;
	logic [SIZE_W-1:0]     frame_height_q;
	logic [DISP_THR_W-1:0] disp_thr_q;
	logic [PCT_W-1:0]      pct_thr_q;
	logic                  cfg_dirty_q;
	gos_geom_t             geom_q;
	gos_reg_t              reg_idx;
	logic                  wr_en;
	logic [SIZE_W-1:0]     w_clamped;
	logic [SIZE_W-1:0]     h_clamped;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = gos_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			disp_thr_q     <= RST_DISP_THR;
			pct_thr_q      <= RST_PCT_THR;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[SIZE_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[SIZE_W-1:0];
				REG_DISP_THR:     disp_thr_q     <= pwdata[DISP_THR_W-1:0];
				REG_PCT_THR:      pct_thr_q      <= pwdata[PCT_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_q);
			REG_DISP_THR:     prdata = APB_DATA_W'(disp_thr_q);
			REG_PCT_THR:      prdata = APB_DATA_W'(pct_thr_q);
			default:          prdata = '0;
		endcase
	end

	// The geometry is one register stage behind the size registers, so the
	// pixel input is held off for the cycle after any write (and after reset).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_dirty_q <= 1'b1;
		end else begin
			cfg_dirty_q <= wr_en;
		end
	end

	assign w_clamped = clamp_size(frame_width_q, (SIZE_W+1)'(MAX_WIDTH));
	assign h_clamped = clamp_size(frame_height_q, (SIZE_W+1)'(MAX_HEIGHT));

	always_ff @(posedge clk) begin
		geom_q.size_w <= w_clamped;
		geom_q.size_h <= h_clamped;
		geom_q.b1_w   <= div3({1'b0, w_clamped});
		geom_q.b2_w   <= div3({w_clamped, 1'b0});
		geom_q.b1_h   <= div3({1'b0, h_clamped});
		geom_q.b2_h   <= div3({h_clamped, 1'b0});
	end

	assign geom     = geom_q;
	assign disp_thr = disp_thr_q;
	assign pct_thr  = pct_thr_q;
	assign cfg_busy = cfg_dirty_q;

endmodule

// ===== sv/gos_datapath.sv =====
// Datapath: pixel position tracking, per-section counters, the restoring
// percentage divider, minimum search and the result register. Depends on gos_pkg.
`include "grid_obstacle_section_select_assert.svh"

module gos_datapath #(
	parameter int MAX_WIDTH      = gos_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT     = gos_pkg::DEF_MAX_HEIGHT,
	parameter int DISPARITY_BITS = gos_pkg::DEF_DISPARITY_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_accept,
	input  logic [DISPARITY_BITS-1:0]      disparity,
	input  gos_pkg::gos_geom_t             geom,
	input  logic [gos_pkg::DISP_THR_W-1:0] disp_thr,
	input  logic [gos_pkg::PCT_W-1:0]      pct_thr,
	input  gos_pkg::gos_cmd_t              cmd,
	output gos_pkg::gos_status_t           status,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic [gos_pkg::SEC_W-1:0]      selected_section,
	output logic                           none_clear,
	output logic [gos_pkg::PCT_W-1:0]      min_percent
);
	import gos_pkg::*;

	localparam int POS_W_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int POS_H_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CMP_W      = (DISPARITY_BITS > DISP_THR_W) ? DISPARITY_BITS : DISP_THR_W;

	logic [POS_W_BITS-1:0] col_q;
	logic [POS_H_BITS-1:0] row_q;
	logic [SIZE_W-1:0]     col_ext, row_ext, col_eff, row_eff, w_m1, h_m1;
	logic                  row_end, frame_end;
	logic [1:0]            band_c, band_r;
	logic [SEC_W-1:0]      sec;
	logic                  above;

	logic                  valid_s1;
	logic                  frame_end_s1;
	logic [SEC_W-1:0]      sec_s1;
	logic                  above_s1;

	logic [CNT_W-1:0]      pix_cnt_q   [NUM_SECTIONS];
	logic [CNT_W-1:0]      above_cnt_q [NUM_SECTIONS];

	logic [NUM_W-1:0]      num_q;
	logic [DEN_W-1:0]      den_q;
	logic [PCT_W-1:0]      quo_q;
	logic                  zero_q;
	logic                  ge;
	logic [PCT_W-1:0]      pct;
	logic [PCT_W-1:0]      best_pct_q;
	logic [SEC_W-1:0]      best_idx_q;

	logic                  out_valid_q;
	logic [SEC_W-1:0]      sel_q;
	logic                  none_clear_q;
	logic [PCT_W-1:0]      min_pct_q;

	// Position of the incoming pixel; positions past the end of a row or of
	// the frame are taken as that end.
	assign w_m1    = geom.size_w - 1'b1;
	assign h_m1    = geom.size_h - 1'b1;
	assign col_ext = SIZE_W'(col_q);
	assign row_ext = SIZE_W'(row_q);
	assign col_eff = (col_ext < geom.size_w) ? col_ext : w_m1;
	assign row_eff = (row_ext < geom.size_h) ? row_ext : h_m1;
	assign row_end   = (col_eff == w_m1);
	assign frame_end = row_end && (row_eff == h_m1);

	assign band_c = (col_eff < geom.b1_w) ? 2'd0 : (col_eff < geom.b2_w) ? 2'd1 : 2'd2;
	assign band_r = (row_eff < geom.b1_h) ? 2'd0 : (row_eff < geom.b2_h) ? 2'd1 : 2'd2;
	assign sec    = SEC_W'(band_r) * SEC_W'(GRID_DIM) + SEC_W'(band_c);
	assign above  = CMP_W'(disparity) > CMP_W'(disp_thr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= POS_H_BITS'(row_eff + 1'b1);
			end else begin
				col_q <= POS_W_BITS'(col_eff + 1'b1);
				row_q <= POS_H_BITS'(row_eff);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			frame_end_s1 <= 1'b0;
		end else begin
			valid_s1     <= in_accept;
			frame_end_s1 <= in_accept & frame_end;
		end
	end

	always_ff @(posedge clk) begin
		sec_s1   <= sec;
		above_s1 <= above;
	end

	// One saturating counter pair per section; each sees only its own enable.
	for (genvar i = 0; i < NUM_SECTIONS; i++) begin : g_cnt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pix_cnt_q[i]   <= '0;
				above_cnt_q[i] <= '0;
			end else if (cmd.publish) begin
				pix_cnt_q[i]   <= '0;
				above_cnt_q[i] <= '0;
			end else if (valid_s1 && sec_s1 == SEC_W'(i)) begin
				if (pix_cnt_q[i] != CNT_MAX) begin
					pix_cnt_q[i] <= pix_cnt_q[i] + 1'b1;
				end
				if (above_s1 && above_cnt_q[i] != CNT_MAX) begin
					above_cnt_q[i] <= above_cnt_q[i] + 1'b1;
				end
			end
		end
	end

	// Restoring division of above*100 by the pixel count. The quotient never
	// exceeds 100, so seven quotient bits cover it, one per step.
	assign ge  = num_q >= NUM_W'(den_q);
	assign pct = zero_q ? PERCENT_FULL : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q  <= NUM_W'(above_cnt_q[cmd.sec_idx]) * PERCENT_MUL;
			den_q  <= {pix_cnt_q[cmd.sec_idx], {(DIV_STEPS-1){1'b0}}};
			quo_q  <= '0;
			zero_q <= (pix_cnt_q[cmd.sec_idx] == '0);
		end else if (cmd.div_step) begin
			if (ge) begin
				num_q <= num_q - NUM_W'(den_q);
			end
			den_q <= den_q >> 1;
			quo_q <= {quo_q[PCT_W-2:0], ge};
		end
	end

	// The first section always loads; later ones replace it only when strictly lower.
	always_ff @(posedge clk) begin
		if (cmd.best_update && (cmd.sec_idx == '0 || pct < best_pct_q)) begin
			best_pct_q <= pct;
			best_idx_q <= cmd.sec_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			sel_q        <= best_idx_q;
			none_clear_q <= !(best_pct_q < pct_thr);
			min_pct_q    <= best_pct_q;
		end
	end

	assign status.frame_end_s1 = valid_s1 & frame_end_s1;
	assign status.out_free     = !out_valid_q || !out_stall;

	assign out_valid        = out_valid_q;
	assign selected_section = sel_q;
	assign none_clear       = none_clear_q;
	assign min_percent      = min_pct_q;

	`GOS_ASSERT_NEXT(a_publish_shows, cmd.publish, out_valid_q, "published result not valid")
	`GOS_ASSERT_SAME(a_pct_range, out_valid_q, min_pct_q <= PERCENT_FULL && sel_q <= LAST_SECTION, "result out of range")
	for (genvar k = 0; k < NUM_SECTIONS; k++) begin : g_chk
		`GOS_ASSERT_SAME(a_above_le_pix, 1'b1, above_cnt_q[k] <= pix_cnt_q[k], "above count exceeds pixel count")
	end

endmodule

// ===== sv/gos_ctrl.sv =====
// Controller state machine: holds off pixels during end-of-frame work or cfg_busy and
// sequences the per-section divider, minimum search and result hand-off. Depends on gos_pkg.
`include "grid_obstacle_section_select_assert.svh"

module gos_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gos_pkg::gos_status_t status,
	input  logic                 cfg_busy,
	output gos_pkg::gos_cmd_t    cmd,
	output logic                 in_stall
);
	import gos_pkg::*;

	gos_state_t        state_q, state_d;
	logic [SEC_W-1:0]  sec_idx_q;
	logic [STEP_W-1:0] step_q;
	logic              sweep_start;
	logic              in_sweep;
	logic              last_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sec_idx_q <= '0;
			step_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				sec_idx_q <= '0;
			end else if (state_q == S_NEXT) begin
				sec_idx_q <= sec_idx_q + 1'b1;
			end
			if (state_q == S_DIV) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (status.frame_end_s1) state_d = S_LOAD;
			end
			S_LOAD: state_d = S_DIV;
			S_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = S_NEXT;
			end
			S_NEXT: begin
				state_d = (sec_idx_q == LAST_SECTION) ? S_DONE : S_LOAD;
			end
			S_DONE: begin
				if (status.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.div_load    = 1'b0;
		cmd.div_step    = 1'b0;
		cmd.best_update = 1'b0;
		cmd.publish     = 1'b0;
		cmd.sec_idx     = sec_idx_q;
		in_stall        = 1'b1;
		unique case (state_q)
			S_IDLE: in_stall = status.frame_end_s1 | cfg_busy;
			S_LOAD: cmd.div_load = 1'b1;
			S_DIV:  cmd.div_step = 1'b1;
			S_NEXT: cmd.best_update = 1'b1;
			S_DONE: cmd.publish = status.out_free;
			default: ;
		endcase
	end

	// The section index passes the last section on the way to S_DONE, and the
	// step count runs one past the last step on the way to S_NEXT.
	assign sweep_start = (state_q == S_IDLE) && status.frame_end_s1;
	assign in_sweep    = (state_q == S_LOAD) || (state_q == S_DIV) || (state_q == S_NEXT);
	assign last_next   = (state_q == S_NEXT) && (sec_idx_q == LAST_SECTION);

	`GOS_ASSERT_NEXT(a_frame_end_starts, sweep_start, state_q == S_LOAD, "sweep did not start")
	`GOS_ASSERT_SAME(a_sec_range, in_sweep, sec_idx_q <= LAST_SECTION, "section out of range")
	`GOS_ASSERT_SAME(a_step_range, state_q == S_DIV, step_q < STEP_W'(DIV_STEPS), "step out of range")
	`GOS_ASSERT_NEXT(a_done_after_last, last_next, state_q == S_DONE, "sweep did not finish")

endmodule
